[rtl/wstp_pkg.sv]
// Shared types, constants and codes for the weighted sorted-table picker.
package wstp_pkg;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned KeyW       = 64;
  localparam int unsigned MoveW      = 16;
  localparam int unsigned WeightW    = 16;
  localparam int unsigned RandW      = 31;
  localparam int unsigned CountW     = 13;
  localparam int unsigned IdxOutW    = 12;
  localparam int unsigned StatusW    = 2;
  // run of equal keys can cover the whole table: sum of weights
  localparam int unsigned SumW       = 32;

  localparam logic [StatusW-1:0] StFound  = 2'd0;
  localparam logic [StatusW-1:0] StEmpty  = 2'd1;
  localparam logic [StatusW-1:0] StAbsent = 2'd2;
  localparam logic [StatusW-1:0] StZero   = 2'd3;

  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_SRCH_WAIT,
    S_CHECK,
    S_SUM,
    S_SUM_WAIT,
    S_DIV,
    S_PICK,
    S_PICK_WAIT,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch request
    logic do_load;     // write request into table
    logic srch_init;
    logic srch_read;   // read mid
    logic srch_step;   // narrow range
    logic scan_init;   // pos <= first, acc <= 0
    logic scan_read;
    logic scan_acc;    // add weight, advance pos
    logic div_init;
    logic div_step;
    logic set_result;
    logic [StatusW-1:0] res_status;
    logic res_move;    // take move from read data
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_query;
    logic count_zero;
    logic srch_done;    // no probe pending and lo >= hi
    logic key_hit;      // read key equals searched key
    logic pos_end;      // pos >= count
    logic sum_zero;
    logic div_done;
    logic run_reached;  // run + weight >= target
  } stat_t;

endpackage

[rtl/wstp_ctrl.sv]
// Controller state machine for the weighted sorted-table picker.
module wstp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  output logic             in_ready,
  output logic             res_load,
  input  logic             res_free,
  input  wstp_pkg::stat_t  st,
  output wstp_pkg::cmd_t   cmd
);

  wstp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wstp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      wstp_pkg::S_IDLE:      if (in_fire) state_next = wstp_pkg::S_SEARCH;
      wstp_pkg::S_SEARCH: begin
        if (!st.is_query || st.count_zero) begin
          state_next = wstp_pkg::S_OUT;
        end else begin
          state_next = wstp_pkg::S_SRCH_WAIT;
        end
      end
      wstp_pkg::S_SRCH_WAIT: begin
        if (st.srch_done) state_next = wstp_pkg::S_CHECK;
      end
      wstp_pkg::S_CHECK: begin
        state_next = st.key_hit ? wstp_pkg::S_SUM : wstp_pkg::S_OUT;
      end
      wstp_pkg::S_SUM: begin
        if (st.pos_end) begin
          state_next = st.sum_zero ? wstp_pkg::S_OUT : wstp_pkg::S_DIV;
        end else begin
          state_next = wstp_pkg::S_SUM_WAIT;
        end
      end
      wstp_pkg::S_SUM_WAIT: begin
        if (st.key_hit) begin
          state_next = wstp_pkg::S_SUM;
        end else begin
          state_next = st.sum_zero ? wstp_pkg::S_OUT : wstp_pkg::S_DIV;
        end
      end
      wstp_pkg::S_DIV:       if (st.div_done) state_next = wstp_pkg::S_PICK;
      wstp_pkg::S_PICK: begin
        state_next = st.pos_end ? wstp_pkg::S_OUT : wstp_pkg::S_PICK_WAIT;
      end
      wstp_pkg::S_PICK_WAIT: begin
        if (!st.key_hit || st.run_reached) begin
          state_next = wstp_pkg::S_OUT;
        end else begin
          state_next = wstp_pkg::S_PICK;
        end
      end
      wstp_pkg::S_OUT:       if (res_free) state_next = wstp_pkg::S_IDLE;
      default:               state_next = wstp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    res_load = 1'b0;
    unique case (state)
      wstp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_fire;
      end
      wstp_pkg::S_SEARCH: begin
        cmd.srch_init = 1'b1;
        cmd.set_result = 1'b1;
        if (!st.is_query) begin
          cmd.do_load = 1'b1;
          cmd.res_status = wstp_pkg::StFound;
        end else begin
          cmd.res_status = st.count_zero ? wstp_pkg::StEmpty : wstp_pkg::StAbsent;
        end
      end
      wstp_pkg::S_SRCH_WAIT: begin
        // read mid, then narrow on the registered key before the next probe
        cmd.srch_step = 1'b1;
        cmd.srch_read = 1'b1;
      end
      wstp_pkg::S_CHECK: begin
        cmd.scan_init = 1'b1;
      end
      wstp_pkg::S_SUM: begin
        cmd.scan_read = !st.pos_end;
        if (st.pos_end) begin
          cmd.set_result = st.sum_zero;
          cmd.res_status = wstp_pkg::StZero;
          cmd.div_init = !st.sum_zero;
        end
      end
      wstp_pkg::S_SUM_WAIT: begin
        cmd.scan_acc = st.key_hit;
        if (!st.key_hit) begin
          cmd.set_result = st.sum_zero;
          cmd.res_status = wstp_pkg::StZero;
          cmd.div_init = !st.sum_zero;
        end
      end
      wstp_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.scan_init = st.div_done;
      end
      wstp_pkg::S_PICK: begin
        cmd.scan_read = !st.pos_end;
      end
      wstp_pkg::S_PICK_WAIT: begin
        cmd.scan_acc = st.key_hit;
        if (st.key_hit && st.run_reached) begin
          cmd.set_result = 1'b1;
          cmd.res_status = wstp_pkg::StFound;
          cmd.res_move = 1'b1;
        end
      end
      wstp_pkg::S_OUT: begin
        res_load = res_free;
      end
      default: ;
    endcase
  end

endmodule

[rtl/wstp_dpath.sv]
// Datapath: table memory, search range, weight scans and modulo unit.
module wstp_dpath #(
  parameter int unsigned TABLE_DEPTH = wstp_pkg::TableDepth
) (
  input  logic                          clk,
  input  logic [wstp_pkg::CountW-1:0]   entry_count,
  input  logic                          in_func,
  input  logic [11:0]                   in_index,
  input  logic [wstp_pkg::KeyW-1:0]     in_key,
  input  logic [wstp_pkg::MoveW-1:0]    in_move,
  input  logic [wstp_pkg::WeightW-1:0]  in_weight,
  input  logic [wstp_pkg::RandW-1:0]    in_rand,
  input  wstp_pkg::cmd_t                cmd,
  output wstp_pkg::stat_t               st,
  output logic [wstp_pkg::StatusW-1:0]  res_status,
  output logic [wstp_pkg::MoveW-1:0]    res_move,
  output logic [wstp_pkg::IdxOutW-1:0]  res_first
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PW = (CW > wstp_pkg::CountW) ? CW : wstp_pkg::CountW;
  localparam int unsigned RW = wstp_pkg::MoveW + wstp_pkg::WeightW;

  logic [wstp_pkg::KeyW-1:0] key_mem [TABLE_DEPTH];
  logic [RW-1:0]             mw_mem  [TABLE_DEPTH];

  logic                      func;
  logic [11:0]               index;
  logic [wstp_pkg::KeyW-1:0] key;
  logic [wstp_pkg::MoveW-1:0] move_w;
  logic [wstp_pkg::WeightW-1:0] weight_w;
  logic [wstp_pkg::RandW-1:0] rnd;

  logic [PW-1:0] count;
  logic [PW-1:0] lo, hi, mid, pos;
  logic [AW-1:0] rd_addr;
  logic [wstp_pkg::KeyW-1:0] rd_key;
  logic [RW-1:0] rd_mw;
  logic          rd_mid;       // last read was a search probe
  logic [wstp_pkg::SumW-1:0] acc, sum;
  logic [wstp_pkg::SumW-1:0] rem;
  logic [wstp_pkg::RandW-1:0] quo;
  logic [4:0]    div_cnt;
  logic [wstp_pkg::SumW:0] rem_sh;
  logic [wstp_pkg::SumW-1:0] target, acc_add;
  logic [PW-1:0] ecount;
  logic          wr_ok;

  assign ecount = PW'(entry_count);
  assign wr_ok  = (PW'(index) < PW'(TABLE_DEPTH)) && (32'(index) < TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func     <= in_func;
      index    <= in_index;
      key      <= in_key;
      move_w   <= in_move;
      weight_w <= in_weight;
      rnd      <= in_rand;
      count    <= (ecount > PW'(TABLE_DEPTH)) ? PW'(TABLE_DEPTH) : ecount;
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.do_load && wr_ok) begin
      key_mem[AW'(index)] <= key;
      mw_mem[AW'(index)]  <= {weight_w, move_w};
    end
    rd_key <= key_mem[rd_addr];
    rd_mw  <= mw_mem[rd_addr];
  end

  assign mid     = lo + ((hi - lo) >> 1);
  assign rd_addr = cmd.srch_read ? mid[AW-1:0] : pos[AW-1:0];

  // search: probe mid this cycle, narrow when its key lands
  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      lo     <= '0;
      hi     <= count - PW'(1);
      rd_mid <= 1'b0;
    end else if (cmd.srch_step) begin
      if (rd_mid) begin
        // narrow on the registered key of the probe; no new probe starts in this step
        if (key <= rd_key) hi <= pos;
        else lo <= pos + PW'(1);
        rd_mid <= 1'b0;
      end else begin
        pos    <= mid;
        rd_mid <= 1'b1;
      end
    end
    if (cmd.scan_init) begin
      pos <= lo;
      acc <= '0;
    end else if (cmd.scan_acc) begin
      acc <= acc_add;
      pos <= pos + PW'(1);
    end
  end

  assign acc_add = acc + wstp_pkg::SumW'(rd_mw[RW-1:wstp_pkg::MoveW]);

  // restoring modulo, one quotient bit per cycle
  assign rem_sh = {rem, quo[wstp_pkg::RandW-1]};
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      sum     <= acc;
      rem     <= '0;
      quo     <= rnd;
      div_cnt <= 5'(wstp_pkg::RandW);
    end else if (cmd.div_step && div_cnt != '0) begin
      quo     <= {quo[wstp_pkg::RandW-2:0], 1'b0};
      div_cnt <= div_cnt - 5'd1;
      if (rem_sh >= {1'b0, sum}) rem <= wstp_pkg::SumW'(rem_sh - {1'b0, sum});
      else rem <= rem_sh[wstp_pkg::SumW-1:0];
    end
  end
  assign target = rem + wstp_pkg::SumW'(1);

  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      res_status <= cmd.res_status;
      res_move   <= cmd.res_move ? rd_mw[wstp_pkg::MoveW-1:0] : '0;
      res_first  <= (cmd.res_status == wstp_pkg::StFound && cmd.res_move) ||
                    cmd.res_status == wstp_pkg::StZero
                    ? wstp_pkg::IdxOutW'(lo) : '0;
    end
  end

  assign st.is_query    = (func == wstp_pkg::FuncQuery);
  assign st.count_zero  = (count == '0);
  assign st.srch_done   = !rd_mid && (lo >= hi);
  assign st.key_hit     = (rd_key == key);
  assign st.pos_end     = (pos >= count);
  assign st.sum_zero    = (acc == '0);
  assign st.div_done    = (div_cnt == '0);
  assign st.run_reached = (acc_add >= target);

endmodule

[rtl/weighted_sorted_table_picker_top.sv]
// Top level of the weighted sorted-table picker.
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid/s_axis_tready    tdata, tuser = func
//  m_axis   out  m_axis_tvalid/m_axis_tready    tdata
//  cfg      in   cfg_valid/cfg_ready            cfg_data = entry_count
// A load passes through the search and output states before the next ready. A query
// runs a binary search over the live count, then two scans of the matching run
// over the single table read port (the sum scan also reads the entry after the
// run), with the modulo between them. Reset clears the controller, the output
// valid flag and entry_count; the table is not cleared. The next request is
// taken once the result is handed over to the output register; a stalled
// output holds it.
module weighted_sorted_table_picker_top #(
  parameter int unsigned TABLE_DEPTH = wstp_pkg::TableDepth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: entry_index[11:0], key[75:12], entry_move[91:76],
  //        entry_weight[107:92], random_value[138:108], zero pad to 144
  input  logic [143:0] s_axis_tdata,
  // tuser: func
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status[1:0], chosen_move[17:2], first_match_res[29:18], pad to 32
  output logic [31:0]  m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [12:0]  cfg_data
);

  wstp_pkg::cmd_t  cmd;
  wstp_pkg::stat_t st;
  logic in_ready, res_load, res_free;
  logic [wstp_pkg::CountW-1:0] entry_count;
  logic [wstp_pkg::StatusW-1:0] res_status;
  logic [wstp_pkg::MoveW-1:0]   res_move;
  logic [wstp_pkg::IdxOutW-1:0] res_first;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = in_ready;
  assign res_free      = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_valid) begin
      entry_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_axis_tdata <= {2'b00, res_first, res_move, res_status};
    end
  end

  wstp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (s_axis_tvalid && in_ready),
    .in_ready (in_ready),
    .res_load (res_load),
    .res_free (res_free),
    .st       (st),
    .cmd      (cmd)
  );

  wstp_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
    .clk         (clk),
    .entry_count (entry_count),
    .in_func     (s_axis_tuser),
    .in_index    (s_axis_tdata[11:0]),
    .in_key      (s_axis_tdata[75:12]),
    .in_move     (s_axis_tdata[91:76]),
    .in_weight   (s_axis_tdata[107:92]),
    .in_rand     (s_axis_tdata[138:108]),
    .cmd         (cmd),
    .st          (st),
    .res_status  (res_status),
    .res_move    (res_move),
    .res_first   (res_first)
  );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the weighted sorted-table picker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = wstp_pkg::TableDepth;
  localparam int unsigned StallLimit = 60000;

  typedef struct packed {
    logic [wstp_pkg::StatusW-1:0] status;
    logic [wstp_pkg::MoveW-1:0]   chosen;
    logic [wstp_pkg::IdxOutW-1:0] first;
  } pick_t;

  typedef enum logic {ROW_ITEM, ROW_COUNT} row_kind_t;

  typedef struct {
    row_kind_t                     kind;
    logic                          func;
    logic [wstp_pkg::IdxOutW-1:0]  idx;
    logic [wstp_pkg::KeyW-1:0]     key;
    logic [wstp_pkg::MoveW-1:0]    mv;
    logic [wstp_pkg::WeightW-1:0]  wt;
    logic [wstp_pkg::RandW-1:0]    rnd;
    bit                            typed;
    pick_t                         res;
  } row_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [12:0]  cfg_data;

  // table mirror, maintained in request order
  logic [wstp_pkg::KeyW-1:0]    key_mirror [Depth];
  logic [wstp_pkg::MoveW-1:0]   move_mirror [Depth];
  logic [wstp_pkg::WeightW-1:0] weight_mirror [Depth];
  bit                           written [Depth];
  logic [wstp_pkg::CountW-1:0]  count_mirror;

  pick_t pending_picks[$];
  row_t  directed[$];
  int    errors;
  int    idle_cycles;
  int    stall_left;
  bit    quiet;

  weighted_sorted_table_picker_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic pick_t pick_move(logic [wstp_pkg::KeyW-1:0] k,
                                      logic [wstp_pkg::RandW-1:0] rnd);
    int unsigned live, lo, hi, mid, pos, total, target, run;
    pick_t p;
    p = '0;
    live = (count_mirror > Depth) ? Depth : int'(count_mirror);
    if (live == 0) begin
      p.status = wstp_pkg::StEmpty;
      return p;
    end
    lo = 0;
    hi = live - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (k <= key_mirror[mid]) hi = mid;
      else lo = mid + 1;
    end
    if (key_mirror[lo] != k) begin
      p.status = wstp_pkg::StAbsent;
      return p;
    end
    p.first = lo[wstp_pkg::IdxOutW-1:0];
    total = 0;
    for (pos = lo; pos < live && key_mirror[pos] == k; pos++) total += weight_mirror[pos];
    p.status = wstp_pkg::StZero;
    if (total == 0) return p;
    target = (rnd % total) + 1;
    run = 0;
    for (pos = lo; pos < live && key_mirror[pos] == k; pos++) begin
      run += weight_mirror[pos];
      if (run >= target) begin
        p.status = wstp_pkg::StFound;
        p.chosen = move_mirror[pos];
        return p;
      end
    end
    return p;
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // one request; starts and ends at a falling edge
  task automatic send_request(logic f, logic [wstp_pkg::IdxOutW-1:0] idx,
                              logic [wstp_pkg::KeyW-1:0] k,
                              logic [wstp_pkg::MoveW-1:0] mv,
                              logic [wstp_pkg::WeightW-1:0] wt,
                              logic [wstp_pkg::RandW-1:0] rnd, bit typed,
                              pick_t typed_res);
    pick_t p;
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = f;
    s_axis_tdata  = {5'b0, rnd, wt, mv, k, idx};
    do @(posedge clk); while (!s_axis_tready);
    if (f == wstp_pkg::FuncLoad) begin
      key_mirror[idx] = k;
      move_mirror[idx] = mv;
      weight_mirror[idx] = wt;
      written[idx] = 1'b1;
      p = '0;
    end else begin
      p = pick_move(k, rnd);
    end
    pending_picks.push_back(typed ? typed_res : p);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  // hold until every result has been taken
  task automatic drain();
    while (pending_picks.size() != 0) @(negedge clk);
  endtask

  // write entry_count once the block has drained
  task automatic set_count(logic [wstp_pkg::CountW-1:0] n);
    drain();
    repeat (8) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = n;
    do @(posedge clk); while (!cfg_ready);
    count_mirror = n;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load(logic [wstp_pkg::IdxOutW-1:0] idx, logic [wstp_pkg::KeyW-1:0] k,
                      logic [wstp_pkg::MoveW-1:0] mv, logic [wstp_pkg::WeightW-1:0] wt);
    send_request(wstp_pkg::FuncLoad, idx, k, mv, wt, wstp_pkg::RandW'($urandom), 1'b0, '0);
  endtask

  // sorted run-structured keys in slots 0..n-1, optionally disordered
  task automatic fill_table(int n, bit disorder);
    logic [wstp_pkg::KeyW-1:0] k;
    logic [wstp_pkg::KeyW-1:0] keys [Depth];
    logic [wstp_pkg::KeyW-1:0] tmp;
    int a, b;
    bit heavy;
    k = {$urandom, $urandom} & 64'hFFFF_FFFF_0000_0000;
    heavy = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) begin
      if (i == 0 || $urandom_range(0, 1) == 0) k = k + $urandom_range(1, 65535);
      keys[i] = k;
    end
    if (disorder) begin
      for (int i = 0; i < 3; i++) begin
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
        tmp = keys[a];
        keys[a] = keys[b];
        keys[b] = tmp;
      end
    end
    for (int i = 0; i < n; i++) begin
      load(i[wstp_pkg::IdxOutW-1:0], keys[i], wstp_pkg::MoveW'($urandom),
           heavy ? 16'hFFFF : ($urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom)));
    end
  endtask

  // write a slot of the sparse full-depth table before it is read
  task automatic touch(int i, logic [wstp_pkg::KeyW-1:0] base);
    if (!written[i]) begin
      load(i[wstp_pkg::IdxOutW-1:0], base + wstp_pkg::KeyW'(i >> 1),
           wstp_pkg::MoveW'($urandom),
           ($urandom_range(0, 3) == 0) ? 16'h0 : wstp_pkg::WeightW'($urandom));
    end
  endtask

  // walk the search and scan of a query, writing every slot it reads
  task automatic prepare_query(logic [wstp_pkg::KeyW-1:0] k, int live,
                               logic [wstp_pkg::KeyW-1:0] base);
    int lo, hi, mid, pos;
    lo = 0;
    hi = live - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      touch(mid, base);
      if (k <= key_mirror[mid]) hi = mid;
      else lo = mid + 1;
    end
    touch(lo, base);
    if (key_mirror[lo] == k) begin
      for (pos = lo; pos < live; pos++) begin
        touch(pos, base);
        if (key_mirror[pos] != k) break;
      end
    end
  endtask

  // queries on a table that is only written where it is read
  task automatic sparse_burst(logic [wstp_pkg::KeyW-1:0] base, int count);
    logic [wstp_pkg::KeyW-1:0] k;
    logic [wstp_pkg::RandW-1:0] rnd;
    int live;
    live = (count_mirror > Depth) ? Depth : int'(count_mirror);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 7))
        0: k = base + wstp_pkg::KeyW'(Depth / 2);
        1: k = {$urandom, $urandom};
        default: k = base + wstp_pkg::KeyW'($urandom_range(0, Depth / 2 - 1));
      endcase
      case ($urandom_range(0, 9))
        0: rnd = '0;
        1: rnd = '1;
        default: rnd = wstp_pkg::RandW'($urandom);
      endcase
      prepare_query(k, live, base);
      send_request(wstp_pkg::FuncQuery, '0, k, '0, '0, rnd, 1'b0, '0);
    end
  endtask

  task automatic query_burst(int n, int count);
    logic [wstp_pkg::KeyW-1:0] k;
    logic [wstp_pkg::RandW-1:0] rnd;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      if (n > 0 && sel < 7) k = key_mirror[$urandom_range(0, n - 1)];
      else if (n > 0 && sel == 7) k = key_mirror[$urandom_range(0, n - 1)] + 1;
      else k = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: rnd = '0;
        1: rnd = '1;
        default: rnd = wstp_pkg::RandW'($urandom);
      endcase
      if (n < Depth && $urandom_range(0, 9) == 0) begin
        // noise write beyond the live part of the table
        load(wstp_pkg::IdxOutW'($urandom_range(n, Depth - 1)), {$urandom, $urandom},
             wstp_pkg::MoveW'($urandom), wstp_pkg::WeightW'($urandom));
      end else begin
        send_request(wstp_pkg::FuncQuery, '0, k, wstp_pkg::MoveW'($urandom),
                     wstp_pkg::WeightW'($urandom), rnd, 1'b0, '0);
      end
    end
  endtask

  function automatic row_t item(logic f, logic [wstp_pkg::IdxOutW-1:0] idx,
                                logic [wstp_pkg::KeyW-1:0] k,
                                logic [wstp_pkg::MoveW-1:0] mv,
                                logic [wstp_pkg::WeightW-1:0] wt,
                                logic [wstp_pkg::RandW-1:0] rnd, bit typed, pick_t res);
    row_t r;
    r.kind = ROW_ITEM;
    r.func = f;
    r.idx = idx;
    r.key = k;
    r.mv = mv;
    r.wt = wt;
    r.rnd = rnd;
    r.typed = typed;
    r.res = res;
    return r;
  endfunction

  function automatic row_t count_row(logic [wstp_pkg::CountW-1:0] n);
    row_t r;
    r = item(wstp_pkg::FuncLoad, '0, '0, '0, '0, '0, 1'b0, '0);
    r.kind = ROW_COUNT;
    r.key = wstp_pkg::KeyW'(n);
    return r;
  endfunction

  // sample results
  always @(posedge clk) begin
    pick_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[1:0];
      got.chosen = m_axis_tdata[17:2];
      got.first  = m_axis_tdata[29:18];
      if (pending_picks.size() == 0) begin
        report($sformatf("result %h with nothing pending", got));
      end else begin
        want = pending_picks.pop_front();
        if (got.status != want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.chosen != want.chosen)
          report($sformatf("chosen_move %h, want %h", got.chosen, want.chosen));
        if (got.first != want.first)
          report($sformatf("first_match_res %0d, want %0d", got.first, want.first));
      end
    end
  end

  // receiver stalls in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      m_axis_tready = 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    row_t r;
    int n;
    logic [wstp_pkg::KeyW-1:0] base;
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = wstp_pkg::FuncLoad;
    m_axis_tready = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    count_mirror = '0;
    errors = 0;
    idle_cycles = 0;
    stall_left = 0;
    quiet = 1'b0;
    foreach (written[i]) written[i] = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed.push_back(item(wstp_pkg::FuncQuery, '0, 64'h5, '0, '0, '0, 1'b1,
                            '{wstp_pkg::StEmpty, 16'h0, 12'd0}));
    directed.push_back(item(wstp_pkg::FuncLoad, 12'd0, 64'h0, 16'h1111, 16'hFFFF, '0,
                            1'b1, '0));
    directed.push_back(item(wstp_pkg::FuncLoad, 12'd1, 64'h5, 16'h2222, 16'h0, '0,
                            1'b1, '0));
    directed.push_back(item(wstp_pkg::FuncLoad, 12'd2, 64'h5, 16'h3333, 16'h0, '0,
                            1'b1, '0));
    directed.push_back(item(wstp_pkg::FuncLoad, 12'd3, '1, 16'hFFFF, 16'h1, '1, 1'b1, '0));
    directed.push_back(count_row(13'd4));
    directed.push_back(item(wstp_pkg::FuncQuery, '0, 64'h5, '0, '0, '1, 1'b1,
                            '{wstp_pkg::StZero, 16'h0, 12'd1}));
    directed.push_back(item(wstp_pkg::FuncQuery, '0, 64'h3, '0, '0, '0, 1'b1,
                            '{wstp_pkg::StAbsent, 16'h0, 12'd0}));
    directed.push_back(item(wstp_pkg::FuncQuery, '0, '1, '1, '1, '1, 1'b1,
                            '{wstp_pkg::StFound, 16'hFFFF, 12'd3}));
    directed.push_back(item(wstp_pkg::FuncQuery, '0, 64'h0, '0, '0, '1, 1'b1,
                            '{wstp_pkg::StFound, 16'h1111, 12'd0}));
    directed.push_back(item(wstp_pkg::FuncLoad, 12'd2, 64'h5, 16'h3333, 16'hFFFF, '0,
                            1'b1, '0));
    directed.push_back(item(wstp_pkg::FuncQuery, '0, 64'h5, '0, '0, '0, 1'b0, '0));
    directed.push_back(item(wstp_pkg::FuncQuery, '0, 64'h5, '0, '0, '1, 1'b0, '0));
    directed.push_back(item(wstp_pkg::FuncLoad, 12'd1, 64'h5, 16'h2222, 16'h7, '0,
                            1'b1, '0));
    directed.push_back(item(wstp_pkg::FuncQuery, '0, 64'h5, '0, '0, 31'd6, 1'b0, '0));
    directed.push_back(item(wstp_pkg::FuncQuery, '0, 64'h5, '0, '0, 31'd7, 1'b0, '0));
    directed.push_back(item(wstp_pkg::FuncLoad, 12'hFFF, '1, '1, '1, '1, 1'b1, '0));
    directed.push_back(count_row(13'd1));
    directed.push_back(item(wstp_pkg::FuncQuery, '0, '1, '0, '0, '0, 1'b1,
                            '{wstp_pkg::StAbsent, 16'h0, 12'd0}));
    directed.push_back(count_row(13'd0));
    directed.push_back(item(wstp_pkg::FuncQuery, '0, 64'h0, '0, '0, '0, 1'b1,
                            '{wstp_pkg::StEmpty, 16'h0, 12'd0}));

    foreach (directed[i]) begin
      r = directed[i];
      if (r.kind == ROW_COUNT) set_count(r.key[wstp_pkg::CountW-1:0]);
      else send_request(r.func, r.idx, r.key, r.mv, r.wt, r.rnd, r.typed, r.res);
    end

    for (int ph = 0; ph < 14; ph++) begin
      quiet = (ph >= 12);
      if (ph == 4) begin
        // full depth, then counts beyond it; slots are written as the search reaches them
        foreach (written[i]) written[i] = 1'b0;
        base = {$urandom, $urandom} & 64'hFFFF_FFFF_0000_0000;
        set_count(13'd4096);
        sparse_burst(base, 30);
        set_count(13'h1FFF);
        sparse_burst(base, 15);
        set_count(13'd4097);
        sparse_burst(base, 10);
      end else if (ph == 9) begin
        set_count(13'd0);
        query_burst(0, 20);
      end else begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 40);
        fill_table(n, ph % 5 == 3);
        set_count(n[wstp_pkg::CountW-1:0]);
        query_burst(n, 50);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
